### hdl/line_rasterizer_macros.svh
// Assertion helpers for the line rasterizer modules; only lr_back includes them.
// Both expect the module to have clk_i and rst_ni in scope.
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

// Property that must hold in the same cycle.
`define LR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define LR_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

### hdl/lr_pkg.sv
package lr_pkg;

  localparam int CoordBits  = 12;
  localparam int SpanBits   = CoordBits + 1;
  localparam int ErrBits    = CoordBits + 3;
  localparam int ColorBits  = 24;
  localparam int DimBits    = 13;
  localparam int CmpBits    = ((CoordBits > DimBits) ? CoordBits : DimBits) + 1;
  localparam int QueueDepth = 2;
  localparam int QPtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntBits   = $clog2(QueueDepth + 1);
  localparam int CfgIdxBits = 2;

  localparam logic [ColorBits-1:0] ResetLineColor = 24'hFF0000;
  localparam logic [DimBits-1:0]   ResetWidth     = 13'd600;
  localparam logic [DimBits-1:0]   ResetHeight    = 13'd400;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [SpanBits-1:0]         span_t;
  typedef logic signed [ErrBits-1:0]   err_t;

  typedef enum logic {
    OpLoad = 1'b0,
    OpStep = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ModeIdle = 4'b0001,
    ModeHorz = 4'b0010,
    ModeVert = 4'b0100,
    ModeDiag = 4'b1000
  } mode_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgLineColor    = 2'd0,
    CfgScreenWidth  = 2'd1,
    CfgScreenHeight = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e    op;
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
    span_t  span_x;
    span_t  span_y;
    logic   xneg;
    logic   yneg;
    err_t   err;
    mode_e  mode;
  } cmd_t;

  typedef struct packed {
    logic [ColorBits-1:0] line_color;
    logic [DimBits-1:0]   width;
    logic [DimBits-1:0]   height;
  } cfg_t;

  // Clamp to [0, dim-1]; with dim of zero the upper bound is -1, so a non-negative v gives -1 and a negative v gives 0.
  function automatic coord_t clamp_dim(coord_t v, logic [DimBits-1:0] dim);
    logic signed [CmpBits-1:0] hi;
    logic signed [CmpBits-1:0] vx;
    logic signed [CmpBits-1:0] r;
    hi = $signed(CmpBits'(dim)) - $signed(CmpBits'(1));
    vx = CmpBits'(v);
    r  = vx;
    if (vx < 0) begin
      r = '0;
    end
    if (hi < vx) begin
      r = hi;
    end
    return coord_t'(r);
  endfunction

endpackage

### hdl/lr_front.sv
module lr_front (
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           op_i,
  input  lr_pkg::coord_t x_start_i,
  input  lr_pkg::coord_t y_start_i,
  input  lr_pkg::coord_t x_end_i,
  input  lr_pkg::coord_t y_end_i,
  input  logic           q_full_i,
  output logic           push_o,
  output lr_pkg::cmd_t   cmd_o
);
  import lr_pkg::*;

  logic signed [SpanBits-1:0] dx;
  logic signed [SpanBits-1:0] dy;
  span_t                      span_x;
  span_t                      span_y;
  mode_e                      mode;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    dx     = SpanBits'(x_end_i) - SpanBits'(x_start_i);
    dy     = SpanBits'(y_end_i) - SpanBits'(y_start_i);
    span_x = (dx < 0) ? span_t'(-dx) : span_t'(dx);
    span_y = (dy < 0) ? span_t'(-dy) : span_t'(dy);
    // The horizontal check comes first, so a single-point line takes that branch and gets ModeIdle (empty).
    if (y_start_i == y_end_i) begin
      mode = (x_start_i < x_end_i) ? ModeHorz : ModeIdle;
    end else if (x_start_i == x_end_i) begin
      mode = (y_start_i < y_end_i) ? ModeVert : ModeIdle;
    end else begin
      mode = ModeDiag;
    end
  end

  always_comb begin
    cmd_o.op     = op_e'(op_i);
    cmd_o.xs     = x_start_i;
    cmd_o.ys     = y_start_i;
    cmd_o.xe     = x_end_i;
    cmd_o.ye     = y_end_i;
    cmd_o.span_x = span_x;
    cmd_o.span_y = span_y;
    cmd_o.xneg   = !(x_start_i < x_end_i);
    cmd_o.yneg   = !(y_start_i < y_end_i);
    cmd_o.err    = $signed(ErrBits'(span_x)) - $signed(ErrBits'(span_y));
    cmd_o.mode   = mode;
  end

endmodule

### hdl/lr_queue.sv
module lr_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  lr_pkg::cmd_t cmd_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output lr_pkg::cmd_t cmd_o
);
  import lr_pkg::*;

  cmd_t                mem_q [QueueDepth];
  logic [QPtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntBits-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntBits'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### hdl/lr_back.sv
`include "line_rasterizer_macros.svh"

module lr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lr_pkg::cfg_t   cfg_i,
  input  logic           q_valid_i,
  input  lr_pkg::cmd_t   cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lr_pkg::coord_t pixel_x_o,
  output lr_pkg::coord_t pixel_y_o,
  output logic [lr_pkg::ColorBits-1:0] pixel_color_o,
  output logic           last_o
);
  import lr_pkg::*;

  mode_e  mode_q, mode_d;
  logic   pend_q, pend_d;
  coord_t cur_x_q, cur_x_d;
  coord_t cur_y_q, cur_y_d;
  coord_t stop_x_q, stop_x_d;
  coord_t stop_y_q, stop_y_d;
  span_t  span_x_q, span_x_d;
  span_t  span_y_q, span_y_d;
  logic   xneg_q, xneg_d;
  logic   yneg_q, yneg_d;
  err_t   err_q, err_d;

  logic                 out_valid_q, out_valid_d;
  coord_t               px_q, py_q;
  logic [ColorBits-1:0] color_q;
  logic                 last_q;

  logic                 out_free;
  logic                 emit;
  coord_t               ex, ey;
  logic [ColorBits-1:0] ecol;
  logic                 elast;

  logic signed [CoordBits:0] x_inc, y_inc;
  logic                      h_last, v_last;
  logic signed [ErrBits:0]   e2;
  logic signed [ErrBits:0]   sx_ext, sy_ext;
  logic                      step_x, step_y;
  coord_t                    nx, ny;

  assign out_free = !out_valid_q || out_ready_i;
  // A load never produces a pixel, so it may retire while the output is stalled.
  assign pop_o    = q_valid_i && ((cmd_i.op == OpLoad) || out_free);

  always_comb begin
    x_inc  = (CoordBits + 1)'(cur_x_q) + $signed((CoordBits + 1)'(1));
    y_inc  = (CoordBits + 1)'(cur_y_q) + $signed((CoordBits + 1)'(1));
    h_last = (x_inc >= (CoordBits + 1)'(stop_x_q));
    v_last = (y_inc >= (CoordBits + 1)'(stop_y_q));
    e2     = $signed({err_q, 1'b0});
    sx_ext = $signed((ErrBits + 1)'(span_x_q));
    sy_ext = $signed((ErrBits + 1)'(span_y_q));
    step_x = (e2 > -sy_ext);
    step_y = (e2 < sx_ext);
    nx     = step_x ? (cur_x_q + (xneg_q ? coord_t'(-1) : coord_t'(1))) : cur_x_q;
    ny     = step_y ? (cur_y_q + (yneg_q ? coord_t'(-1) : coord_t'(1))) : cur_y_q;
  end

  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    stop_x_d = stop_x_q;
    stop_y_d = stop_y_q;
    span_x_d = span_x_q;
    span_y_d = span_y_q;
    xneg_d   = xneg_q;
    yneg_d   = yneg_q;
    err_d    = err_q;
    emit     = 1'b0;
    ex       = cur_x_q;
    ey       = cur_y_q;
    ecol     = '0;
    elast    = 1'b0;
    if (pop_o) begin
      if (cmd_i.op == OpLoad) begin
        mode_d   = cmd_i.mode;
        pend_d   = (cmd_i.mode == ModeDiag);
        cur_x_d  = cmd_i.xs;
        cur_y_d  = cmd_i.ys;
        stop_x_d = cmd_i.xe;
        stop_y_d = cmd_i.ye;
        span_x_d = cmd_i.span_x;
        span_y_d = cmd_i.span_y;
        xneg_d   = cmd_i.xneg;
        yneg_d   = cmd_i.yneg;
        err_d    = cmd_i.err;
      end else begin
        unique case (mode_q)
          ModeHorz: begin
            emit    = 1'b1;
            ex      = clamp_dim(cur_x_q, cfg_i.width);
            ey      = clamp_dim(cur_y_q, cfg_i.height);
            elast   = h_last;
            cur_x_d = cur_x_q + coord_t'(1);
            if (h_last) begin
              mode_d = ModeIdle;
            end
          end
          ModeVert: begin
            emit    = 1'b1;
            ex      = clamp_dim(cur_x_q, cfg_i.width);
            ey      = clamp_dim(cur_y_q, cfg_i.height);
            elast   = v_last;
            cur_y_d = cur_y_q + coord_t'(1);
            if (v_last) begin
              mode_d = ModeIdle;
            end
          end
          ModeDiag: begin
            emit = 1'b1;
            ecol = cfg_i.line_color;
            if (pend_q) begin
              // The end point goes out ahead of the stepped pixels.
              pend_d = 1'b0;
              ex     = stop_x_q;
              ey     = stop_y_q;
            end else begin
              err_d   = err_q - (step_x ? $signed(ErrBits'(span_y_q)) : err_t'(0))
                              + (step_y ? $signed(ErrBits'(span_x_q)) : err_t'(0));
              cur_x_d = nx;
              cur_y_d = ny;
              elast   = (nx == stop_x_q) && (ny == stop_y_q);
              if (elast) begin
                mode_d = ModeIdle;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeIdle;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q  <= cur_x_d;
    cur_y_q  <= cur_y_d;
    stop_x_q <= stop_x_d;
    stop_y_q <= stop_y_d;
    span_x_q <= span_x_d;
    span_y_q <= span_y_d;
    xneg_q   <= xneg_d;
    yneg_q   <= yneg_d;
    err_q    <= err_d;
    if (emit) begin
      px_q    <= ex;
      py_q    <= ey;
      color_q <= ecol;
      last_q  <= elast;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = color_q;
  assign last_o        = last_q;

  `LR_ASSERT(a_pend_only_diag, !pend_q || (mode_q == ModeDiag), "end pixel pending outside a diagonal")
  `LR_ASSERT(a_horz_before_stop, (mode_q != ModeHorz) || (cur_x_q < stop_x_q), "horizontal run passed its end")
  `LR_ASSERT(a_step_needs_slot, !(pop_o && (cmd_i.op == OpStep)) || out_free, "step retired into a full output register")
  `LR_ASSERT_NEXT(a_last_goes_idle, pop_o && emit && elast, mode_q == ModeIdle, "line still active after its last pixel")

endmodule

### hdl/line_rasterizer.sv
// A step request is written into the command queue when accepted; at the head,
// with the output free, its pixel is registered at the output. Throughput: one
// transaction per cycle unless the queue is full or the output stalls; the back
// end does one error update and compare per cycle; a load emits no pixel.
// Reset (async, active low) empties the queue, idles the line and restores
// line_color 0xFF0000 and a 600 by 400 screen.
module line_rasterizer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic signed [lr_pkg::CoordBits-1:0] x_start_i,
  input  logic signed [lr_pkg::CoordBits-1:0] y_start_i,
  input  logic signed [lr_pkg::CoordBits-1:0] x_end_i,
  input  logic signed [lr_pkg::CoordBits-1:0] y_end_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [lr_pkg::CoordBits-1:0] pixel_x_o,
  output logic signed [lr_pkg::CoordBits-1:0] pixel_y_o,
  output logic [lr_pkg::ColorBits-1:0]   pixel_color_o,
  output logic                           last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lr_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [lr_pkg::ColorBits-1:0]   cfg_data_i
);
  import lr_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t head_cmd;
  logic pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgLineColor:    cfg_d.line_color = cfg_data_i;
        CfgScreenWidth:  cfg_d.width      = cfg_data_i[DimBits-1:0];
        CfgScreenHeight: cfg_d.height     = cfg_data_i[DimBits-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_color <= ResetLineColor;
      cfg_q.width      <= ResetWidth;
      cfg_q.height     <= ResetHeight;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lr_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .x_start_i  (x_start_i),
    .y_start_i  (y_start_i),
    .x_end_i    (x_end_i),
    .y_end_i    (y_end_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  lr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  lr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_o        (last_o)
  );

endmodule
